>>> src/kway_merge_by_key_chunked_assert.svh
// Assertion macros used by the checker file.
`ifndef KWAY_MERGE_BY_KEY_CHUNKED_ASSERT_SVH
`define KWAY_MERGE_BY_KEY_CHUNKED_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define KMERGE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KMERGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/kmerge_pkg.sv
`default_nettype none

package kmerge_pkg;

  // Field widths fixed by the item and result formats
  localparam int OP_BITS        = 2;
  localparam int SOURCE_BITS    = 6;
  localparam int KEY_FIELD_BITS = 16;
  localparam int CHUNK_BITS     = 16;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Default sizing
  localparam int MAX_SOURCES_DEF = 64;
  localparam int KEY_BITS_DEF    = 16;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;

  // Status codes
  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ASCENDING    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHUNK_LENGTH = 2'd1;

  // Register reset values
  localparam logic                  ASCENDING_RST    = 1'b1;
  localparam logic [CHUNK_BITS-1:0] CHUNK_LENGTH_RST = 16'd1024;

endpackage

`default_nettype wire

>>> src/kmerge_if.sv
`default_nettype none

// Input item channel
interface kmerge_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [kmerge_pkg::OP_BITS-1:0]        op;
  logic [kmerge_pkg::SOURCE_BITS-1:0]    source_id;
  logic [kmerge_pkg::KEY_FIELD_BITS-1:0] head_key;

  modport source (output valid, op, source_id, head_key, input ready);
  modport sink (input valid, op, source_id, head_key, output ready);
endinterface

// Result channel
interface kmerge_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [kmerge_pkg::SOURCE_BITS-1:0]    winner_source;
  logic [kmerge_pkg::KEY_FIELD_BITS-1:0] winner_key;
  logic                                 chunk_end;
  logic [kmerge_pkg::CHUNK_BITS-1:0]     chunk_records;
  logic [kmerge_pkg::STATUS_BITS-1:0]    status;

  modport source (output valid, winner_source, winner_key, chunk_end, chunk_records, status,
                  input ready);
  modport sink (input valid, winner_source, winner_key, chunk_end, chunk_records, status,
                output ready);
endinterface

// Register write channel
interface kmerge_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [kmerge_pkg::CFG_INDEX_BITS-1:0] index;
  logic [kmerge_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/kway_merge_by_key_chunked.sv
// K-way merge engine with chunk counting.
// Channels: item (op, source_id, head_key) in, result out, cfg for register
// writes (index 0 ascending_order, 1 chunk_length); cfg is always ready.
// One result beat per item. Insert, finish, unknown ops and a pop on an
// empty store go from accept straight to the emit state. A pop over n
// pending entries (best at slot b) scans the entry memory one slot per
// cycle, then moves every slot after b down one place, each by a read and
// then a write; a closing read, the count update and the emit follow.
// item.ready is high only between items; a new item is taken while the
// last result still sits in the output register. If the receiver stalls,
// the next finished result waits in the sequencer until the output
// register frees, and no further item is taken meanwhile.
// Reset (rst, synchronous) empties the store, clears the chunk counter and
// restores the registers to ascending order and chunk length 1024. The
// entry memory is not cleared: the fill count tracks the live slots.
`default_nettype none

module kway_merge_by_key_chunked #(
  parameter int MAX_SOURCES = kmerge_pkg::MAX_SOURCES_DEF,
  parameter int KEY_BITS    = kmerge_pkg::KEY_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  kmerge_item_if.sink    item,
  kmerge_result_if.source result,
  kmerge_cfg_if.sink     cfg
);

  localparam int IW = $clog2(MAX_SOURCES);
  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SOURCES);

  typedef struct packed {
    logic [kmerge_pkg::SOURCE_BITS-1:0] src;
    logic [KEY_BITS-1:0]                key;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_POP_END, S_EMIT
  } state_t;

  state_t state;

  // Registers
  logic                                  ascending;
  logic [kmerge_pkg::CHUNK_BITS-1:0]     chunk_length;
  logic [kmerge_pkg::CHUNK_BITS-1:0]     records;
  logic [CW-1:0]                         count;
  logic [IW-1:0]                         scan_idx;
  logic [IW-1:0]                         best_idx;
  logic [IW-1:0]                         sh_idx;
  logic [KEY_BITS-1:0]                   best_key;
  logic [kmerge_pkg::SOURCE_BITS-1:0]    best_src;

  // Pending result
  logic [kmerge_pkg::SOURCE_BITS-1:0]    res_src;
  logic [kmerge_pkg::KEY_FIELD_BITS-1:0] res_key;
  logic                                  res_end;
  logic [kmerge_pkg::CHUNK_BITS-1:0]     res_rec;
  logic [kmerge_pkg::STATUS_BITS-1:0]    res_status;

  // Entry memory
  entry_t        mem [MAX_SOURCES];
  entry_t        rd_data;
  logic [IW-1:0] mem_raddr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic                              accept;
  logic [KEY_BITS-1:0]               key_in;
  logic                              cand_wins;
  logic                              scan_last;
  logic                              shift_more;
  logic                              not_full;
  logic [kmerge_pkg::CHUNK_BITS-1:0] rec_inc;
  logic [kmerge_pkg::CHUNK_BITS-1:0] limit;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;
  assign key_in     = KEY_BITS'(item.head_key);
  assign not_full   = (count < MAX_COUNT);

  // Compare unit: first slot seeds, later slots win only when strictly better
  assign cand_wins = (scan_idx == '0) ||
                     (ascending ? (rd_data.key < best_key) : (rd_data.key > best_key));
  assign scan_last  = ((CW'(scan_idx) + CW'(1)) == count);
  assign shift_more = ((CW'(sh_idx) + CW'(1)) < count);

  // Chunk counter
  assign rec_inc = records + kmerge_pkg::CHUNK_BITS'(1);
  assign limit   = (chunk_length == '0) ? kmerge_pkg::CHUNK_BITS'(1) : chunk_length;

  // Memory read address
  always_comb begin
    unique case (state)
      S_SCAN:     mem_raddr = scan_idx + IW'(1);
      S_SHIFT_RD: mem_raddr = sh_idx + IW'(1);
      default:    mem_raddr = '0;
    endcase
  end

  // Memory write: append on insert, move down during the shift
  always_comb begin
    if (state == S_SHIFT_WR) begin
      mem_we    = 1'b1;
      mem_waddr = sh_idx;
      mem_wdata = rd_data;
    end else begin
      mem_we        = accept && (item.op == kmerge_pkg::OP_INSERT) && not_full;
      mem_waddr     = IW'(count);
      mem_wdata.src = item.source_id;
      mem_wdata.key = key_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Sequencer, registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      records      <= '0;
      ascending    <= kmerge_pkg::ASCENDING_RST;
      chunk_length <= kmerge_pkg::CHUNK_LENGTH_RST;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          kmerge_pkg::REG_ASCENDING:    ascending <= cfg.data[0];
          kmerge_pkg::REG_CHUNK_LENGTH: chunk_length <= cfg.data;
          default: ;
        endcase
      end

      // Taken beat frees the output register; S_EMIT handles its own reload
      if (result.valid && result.ready && (state != S_EMIT)) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_src    <= '0;
            res_key    <= '0;
            res_end    <= 1'b0;
            res_rec    <= '0;
            res_status <= kmerge_pkg::STATUS_OK;
            state      <= S_EMIT;
            case (item.op)
              kmerge_pkg::OP_INSERT: begin
                if (not_full) begin
                  count <= count + CW'(1);
                end else begin
                  res_status <= kmerge_pkg::STATUS_FULL;
                end
              end
              kmerge_pkg::OP_POP: begin
                if (count == '0) begin
                  res_status <= kmerge_pkg::STATUS_EMPTY;
                end else begin
                  scan_idx <= '0;
                  state    <= S_SCAN;
                end
              end
              kmerge_pkg::OP_FINISH: begin
                if (records != '0) begin
                  res_end <= 1'b1;
                  res_rec <= records;
                  records <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (cand_wins) begin
            best_idx <= scan_idx;
            best_key <= rd_data.key;
            best_src <= rd_data.src;
          end
          if (scan_last) begin
            sh_idx <= cand_wins ? scan_idx : best_idx;
            state  <= S_SHIFT_RD;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_SHIFT_RD: begin
          state <= shift_more ? S_SHIFT_WR : S_POP_END;
        end
        S_SHIFT_WR: begin
          sh_idx <= sh_idx + IW'(1);
          state  <= S_SHIFT_RD;
        end
        S_POP_END: begin
          count   <= count - CW'(1);
          res_src <= best_src;
          res_key <= kmerge_pkg::KEY_FIELD_BITS'(best_key);
          if (rec_inc >= limit) begin
            res_end <= 1'b1;
            res_rec <= rec_inc;
            records <= '0;
          end else begin
            records <= rec_inc;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.winner_source <= res_src;
            result.winner_key    <= res_key;
            result.chunk_end     <= res_end;
            result.chunk_records <= res_rec;
            result.status        <= res_status;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/kmerge_checker.sv
`default_nettype none

`include "kway_merge_by_key_chunked_assert.svh"

module kmerge_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  item_valid,
  input logic                                  item_ready,
  input logic                                  result_valid,
  input logic                                  result_ready,
  input logic [kmerge_pkg::SOURCE_BITS-1:0]    winner_source,
  input logic [kmerge_pkg::KEY_FIELD_BITS-1:0] winner_key,
  input logic                                  chunk_end,
  input logic [kmerge_pkg::CHUNK_BITS-1:0]     chunk_records,
  input logic [kmerge_pkg::STATUS_BITS-1:0]    status
);

  // A stalled result beat holds
  `KMERGE_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(winner_source) && $stable(winner_key) && $stable(chunk_end) && $stable(chunk_records) && $stable(status), "stalled result beat changed")

  // One item at a time: no accept in the cycle after an accept
  `KMERGE_ASSERT(a_busy_after_accept, clk, rst, item_valid && item_ready |=> !item_ready, "item taken while busy")

  // An empty pop carries no winner and closes no chunk
  `KMERGE_ASSERT(a_empty_pop_zero, clk, rst, result_valid && (status == kmerge_pkg::STATUS_EMPTY) |-> (winner_source == '0) && (winner_key == '0) && !chunk_end, "empty pop has payload")

  // A record count appears only with a chunk close
  `KMERGE_ASSERT(a_chunk_records, clk, rst, result_valid && !chunk_end |-> chunk_records == '0, "chunk count without chunk end")

  // No result beat right after reset
  `KMERGE_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> !result_valid, "result valid after reset")

endmodule

bind kway_merge_by_key_chunked kmerge_checker u_kmerge_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .winner_source (result.winner_source),
  .winner_key    (result.winner_key),
  .chunk_end     (result.chunk_end),
  .chunk_records (result.chunk_records),
  .status        (result.status)
);

`default_nettype wire
